// ----- hdl/dbffa_pkg.sv -----
// ----------------------------------------------------------------------------
// dbffa_pkg
// Shared types and constants for the dual bitmap first-free allocator.
// ----------------------------------------------------------------------------
package dbffa_pkg;

  localparam int MAP_ENTRIES_DEF = 4096;
  localparam int WORD_BITS_DEF   = 32;

  localparam int LIMIT_W = 13;
  localparam int INDEX_W = 12;
  localparam int OP_W    = 2;
  localparam int STS_W   = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4096);

  // request codes
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_MARK    = 2'd2;

  // result status codes
  localparam logic [STS_W-1:0] STS_DONE  = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
  localparam logic [STS_W-1:0] STS_RANGE = 2'd2;

  // map select codes
  localparam logic MAP_INODE = 1'b0;
  localparam logic MAP_DATA  = 1'b1;

  // register indexes on the apb port
  localparam logic REG_INODE_LIMIT = 1'b0;
  localparam logic REG_DATA_LIMIT  = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic               map_select;
    logic [INDEX_W-1:0] entry_index;
  } dbffa_req_t;

  typedef struct packed {
    logic [STS_W-1:0]   status;
    logic [INDEX_W-1:0] result_index;
  } dbffa_rsp_t;

endpackage

// ----- hdl/dual_bitmap_first_free_allocator.sv -----
// ----------------------------------------------------------------------------
// dual_bitmap_first_free_allocator
// Keeps an inode bitmap and a data block bitmap and serves allocate, release
// and mark-used requests against them.
// ----------------------------------------------------------------------------
// Both bitmaps live in one synchronous memory of WORD_BITS-wide words. After
// reset a clearing pass writes zero to every word of the memory while busy
// stays high; configuration writes are taken during it. Release, mark-used
// and the unused op code do one memory read, then the check and write-back.
// Allocate reads and checks n words in turn, up to and including the one with
// the lowest free entry, or all of them when the map is full (at least one,
// at most max(1, ceil(min(limit, MAP_ENTRIES)/WORD_BITS)), 128 at the
// defaults); the single memory read port delivers one word per cycle. The
// result strobe result_valid_o is high for one cycle and cannot be held off;
// a new item may be started in that same cycle.
module dual_bitmap_first_free_allocator
  import dbffa_pkg::*;
#(
  parameter int MAP_ENTRIES = MAP_ENTRIES_DEF,
  parameter int WORD_BITS   = WORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        start,
  output logic        busy,
  input  dbffa_req_t  item_i,
  // result channel
  output logic        result_valid_o,
  output dbffa_rsp_t  result_o,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int MAP_WORDS = (MAP_ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int WB_W      = $clog2(WORD_BITS);
  localparam int WA_W      = $clog2(MAP_WORDS);
  localparam int MEM_DEPTH = 2 * MAP_WORDS;
  localparam int MA_W      = WA_W + 1;
  localparam int POS_W     = WA_W + WB_W;
  localparam int CMP_W     = (LIMIT_W > POS_W + 1) ? LIMIT_W : POS_W + 1;
  localparam int LW_W      = CMP_W - WB_W;

  localparam logic [CMP_W-1:0] MAP_ENTRIES_C = CMP_W'(MAP_ENTRIES);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EVAL  = 2'd2;

  // configuration registers
  logic [LIMIT_W-1:0] inode_limit_q;
  logic [LIMIT_W-1:0] data_limit_q;
  logic               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inode_limit_q <= LIMIT_RESET;
      data_limit_q  <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_INODE_LIMIT: inode_limit_q <= pwdata[LIMIT_W-1:0];
        REG_DATA_LIMIT:  data_limit_q  <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_INODE_LIMIT: prdata = 32'(inode_limit_q);
      REG_DATA_LIMIT:  prdata = 32'(data_limit_q);
      default:         prdata = '0;
    endcase
  end

  // bitmap memory, inode map in the lower half and data map in the upper
  logic [WORD_BITS-1:0] mem [MEM_DEPTH];
  logic                 mem_we;
  logic [MA_W-1:0]      mem_wa;
  logic [WORD_BITS-1:0] mem_wd;
  logic                 mem_re;
  logic [MA_W-1:0]      mem_ra;
  logic [WORD_BITS-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  // control and item registers
  logic [1:0]         state_q, state_d;
  logic [MA_W-1:0]    clr_q, clr_d;
  logic [WA_W:0]      word_q, word_d;
  logic [OP_W-1:0]    op_q, op_d;
  logic               sel_q, sel_d;
  logic [INDEX_W-1:0] idx_q, idx_d;
  logic [CMP_W-1:0]   lim_q, lim_d;
  logic               rvalid_q, rvalid_d;
  dbffa_rsp_t         rsp_q, rsp_d;

  // request decode
  logic [LIMIT_W-1:0] lim_sel;
  logic [CMP_W-1:0]   lim_ext;
  logic [CMP_W-1:0]   idx_in_ext;

  // scan evaluation
  logic [LW_W-1:0]      lim_word;
  logic [WB_W-1:0]      lim_rem;
  logic [LW_W-1:0]      word_ext;
  logic [LW_W-1:0]      word_nxt;
  logic [WORD_BITS-1:0] valid_mask;
  logic [WORD_BITS-1:0] free_bits;
  logic [WORD_BITS-1:0] lowest;
  logic [WB_W-1:0]      pos;
  logic [CMP_W-1:0]     idx_q_ext;
  logic [WORD_BITS-1:0] idx_bit;
  logic                 more_words;

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = rvalid_q;
  assign result_o       = rsp_q;

  assign lim_sel    = (item_i.map_select == MAP_DATA) ? data_limit_q : inode_limit_q;
  assign lim_ext    = CMP_W'(lim_sel);
  assign idx_in_ext = CMP_W'(item_i.entry_index);

  assign lim_word  = lim_q[CMP_W-1:WB_W];
  assign lim_rem   = lim_q[WB_W-1:0];
  assign word_ext  = LW_W'(word_q);
  assign word_nxt  = word_ext + LW_W'(1);
  assign idx_q_ext = CMP_W'(idx_q);

  // entries at or above the limit count as used
  always_comb begin
    if (word_ext < lim_word) begin
      valid_mask = '1;
    end else if (word_ext == lim_word) begin
      valid_mask = ~({WORD_BITS{1'b1}} << lim_rem);
    end else begin
      valid_mask = '0;
    end
  end

  assign free_bits  = ~rd_q & valid_mask;
  assign lowest     = free_bits & (~free_bits + WORD_BITS'(1));
  assign idx_bit    = WORD_BITS'(1) << idx_q[WB_W-1:0];
  assign more_words = (word_nxt < lim_word) || ((word_nxt == lim_word) && (lim_rem != '0));

  always_comb begin
    pos = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (lowest[b]) begin
        pos = pos | WB_W'(b);
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    word_d   = word_q;
    op_d     = op_q;
    sel_d    = sel_q;
    idx_d    = idx_q;
    lim_d    = lim_q;
    rvalid_d = 1'b0;
    rsp_d    = rsp_q;
    mem_we   = 1'b0;
    mem_wa   = {sel_q, word_q[WA_W-1:0]};
    mem_wd   = rd_q;
    mem_re   = 1'b0;
    mem_ra   = {sel_q, word_q[WA_W-1:0]};

    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = '0;
        clr_d  = clr_q + MA_W'(1);
        if (clr_q == MA_W'(MEM_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          op_d   = item_i.op;
          sel_d  = item_i.map_select;
          idx_d  = item_i.entry_index;
          lim_d  = (lim_ext > MAP_ENTRIES_C) ? MAP_ENTRIES_C : lim_ext;
          word_d = (item_i.op == OP_ALLOC) ? '0 : idx_in_ext[WB_W +: WA_W+1];
          mem_re = 1'b1;
          mem_ra = {item_i.map_select, word_d[WA_W-1:0]};
          state_d = S_EVAL;
        end
      end

      S_EVAL: begin
        rsp_d.result_index = idx_q;
        rsp_d.status       = STS_DONE;
        case (op_q)
          OP_ALLOC: begin
            if (free_bits != '0) begin
              mem_we             = 1'b1;
              mem_wd             = rd_q | lowest;
              rsp_d.result_index = INDEX_W'({word_q[WA_W-1:0], pos});
              rvalid_d           = 1'b1;
              state_d            = S_IDLE;
            end else if (more_words) begin
              // read of the next word is issued while this one is checked
              word_d = word_q + (WA_W+1)'(1);
              mem_re = 1'b1;
              mem_ra = {sel_q, word_d[WA_W-1:0]};
            end else begin
              rsp_d.status       = STS_FULL;
              rsp_d.result_index = '0;
              rvalid_d           = 1'b1;
              state_d            = S_IDLE;
            end
          end
          OP_RELEASE, OP_MARK: begin
            if (idx_q_ext < lim_q) begin
              mem_we = 1'b1;
              mem_wd = (op_q == OP_MARK) ? (rd_q | idx_bit) : (rd_q & ~idx_bit);
            end else begin
              rsp_d.status = STS_RANGE;
            end
            rvalid_d = 1'b1;
            state_d  = S_IDLE;
          end
          default: begin
            rvalid_d = 1'b1;
            state_d  = S_IDLE;
          end
        endcase
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      rvalid_q <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    op_q   <= op_d;
    sel_q  <= sel_d;
    idx_q  <= idx_d;
    lim_q  <= lim_d;
    rsp_q  <= rsp_d;
  end

endmodule

// ----- hdl/dbffa_checker.sv -----
// ----------------------------------------------------------------------------
// dbffa_checker
// Port-level checks on the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module dbffa_checker
  import dbffa_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       result_valid_o,
  input dbffa_rsp_t result_o
);

  // an accepted item raises busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // a result only follows a busy cycle and leaves the block ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (!busy && $past(busy)))
    else $error("result strobe without preceding work");

  // result strobes never come two in a row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("back to back result strobes");

  // a full map reports index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.status == STS_FULL)) |-> (result_o.result_index == '0))
    else $error("full status with non-zero index");

endmodule

bind dual_bitmap_first_free_allocator dbffa_checker u_dbffa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
